// ===== src/gated_matrix_slice_accumulator_top_assert.svh =====
// Assertion macros used by the controller of the gated slice accumulator.
`ifndef GATED_MATRIX_SLICE_ACCUMULATOR_TOP_ASSERT_SVH
`define GATED_MATRIX_SLICE_ACCUMULATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gmsa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GMSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gmsa assertion failed");

`endif

// ===== src/gmsa_pkg.sv =====
package gmsa_pkg;

    // Sizes of the slice store.
    localparam int GATES     = 4;
    localparam int CHANNELS  = 8192;
    localparam int CH_W      = 13;
    localparam int ADDR_W    = $clog2(CHANNELS);
    localparam int GATE_W    = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int GI_W      = 2;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;

    // Request opcodes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ELEM  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Slice modes.
    localparam logic [1:0] MODE_X   = 2'd0;
    localparam logic [1:0] MODE_Y   = 2'd1;
    localparam logic [1:0] MODE_SUM = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_GATES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_COUNT = 2'd2;

    // One memory row holds the entry of every gate for one channel.
    typedef logic [GATES-1:0][DATA_W-1:0] t_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic load_win;
        logic clr_step;
        logic rd_col;
        logic rd_row;
        logic wr_x;
        logic wr_y;
        logic sum_init;
        logic sum_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic sum_last;
    } t_status;

    // True when a channel lies inside the slice store.
    function automatic logic ch_in_range(input logic [CH_W-1:0] ch);
        return (int'(ch) < CHANNELS);
    endfunction

endpackage

// ===== src/gmsa_ctrl.sv =====
module gmsa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_opcode,
    input  gmsa_pkg::t_status    i_status,
    output logic                 o_busy,
    output gmsa_pkg::t_cmd       o_cmd
);

    `include "gated_matrix_slice_accumulator_top_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_RD_X  = 3'd2;
    localparam logic [2:0] S_WB_X  = 3'd3;
    localparam logic [2:0] S_RD_Y  = 3'd4;
    localparam logic [2:0] S_WB_Y  = 3'd5;
    localparam logic [2:0] S_RD_R  = 3'd6;
    localparam logic [2:0] S_SUM   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    // Next state and commands for the current step.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    case (i_opcode)
                        gmsa_pkg::OP_LOAD:  o_cmd.load_win = 1'b1;
                        gmsa_pkg::OP_CLEAR: n_state = S_CLEAR;
                        gmsa_pkg::OP_ELEM:  n_state = S_RD_X;
                        gmsa_pkg::OP_READ:  n_state = S_RD_R;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_X: begin
                o_cmd.rd_col = 1'b1;
                n_state      = S_WB_X;
            end
            S_WB_X: begin
                o_cmd.wr_x = 1'b1;
                n_state    = S_RD_Y;
            end
            S_RD_Y: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_WB_Y;
            end
            S_WB_Y: begin
                o_cmd.wr_y = 1'b1;
                n_state    = S_IDLE;
            end
            S_RD_R: begin
                o_cmd.rd_col   = 1'b1;
                o_cmd.sum_init = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The store is swept clean after reset before the first request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `GMSA_ASSERT_NEXT(a_elem_starts, i_clk, i_rst_n,
        accept && (i_opcode == gmsa_pkg::OP_ELEM), r_state == S_RD_X)
    `GMSA_ASSERT_NEXT(a_x_then_y, i_clk, i_rst_n, r_state == S_WB_X, r_state == S_RD_Y)
    `GMSA_ASSERT_NEXT(a_sum_ends, i_clk, i_rst_n,
        (r_state == S_SUM) && i_status.sum_last, r_state == S_IDLE)
    `GMSA_ASSERT_NEXT(a_clear_holds, i_clk, i_rst_n,
        (r_state == S_CLEAR) && !i_status.clr_last, r_state == S_CLEAR && o_busy)

endmodule

// ===== src/gmsa_dpath.sv =====
module gmsa_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gmsa_pkg::t_cmd                     i_cmd,
    output gmsa_pkg::t_status                  o_status,
    input  logic [gmsa_pkg::GI_W-1:0]          i_gate_index,
    input  logic [gmsa_pkg::CH_W-1:0]          i_gate_low,
    input  logic [gmsa_pkg::CH_W-1:0]          i_gate_high,
    input  logic [gmsa_pkg::CH_W-1:0]          i_row,
    input  logic [gmsa_pkg::CH_W-1:0]          i_column,
    input  logic signed [gmsa_pkg::DATA_W-1:0] i_count,
    input  logic                               i_cfg_we,
    input  logic [gmsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gmsa_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_valid,
    output logic signed [gmsa_pkg::DATA_W-1:0] o_slice_value
);

    localparam logic [gmsa_pkg::CH_W-1:0] CH_MAX = gmsa_pkg::CH_W'(gmsa_pkg::CHANNELS - 1);

    // Configuration registers.
    logic [1:0] r_slice_mode;
    logic       r_sum_gates;
    logic [2:0] r_gate_count;

    // Gate windows.
    logic [gmsa_pkg::CH_W-1:0] r_win_lo [gmsa_pkg::GATES];
    logic [gmsa_pkg::CH_W-1:0] r_win_hi [gmsa_pkg::GATES];

    // Latched request fields.
    logic [gmsa_pkg::GI_W-1:0]   r_gi;
    logic [gmsa_pkg::CH_W-1:0]   r_row;
    logic [gmsa_pkg::CH_W-1:0]   r_col;
    logic [gmsa_pkg::DATA_W-1:0] r_cnt;

    // Slice store: one row per channel, one word per gate.
    gmsa_pkg::t_row mem [gmsa_pkg::CHANNELS];
    gmsa_pkg::t_row r_rd_data;

    logic [gmsa_pkg::ADDR_W-1:0] r_clr_addr;
    logic [gmsa_pkg::GATE_W-1:0] r_gate;
    logic [gmsa_pkg::DATA_W-1:0] r_acc;
    logic                        r_valid;
    logic [gmsa_pkg::DATA_W-1:0] r_out;

    logic [gmsa_pkg::CH_W-1:0]   hi_c;
    logic [gmsa_pkg::CH_W-1:0]   new_lo;
    logic [gmsa_pkg::CH_W-1:0]   new_hi;
    logic [gmsa_pkg::GATES-1:0]  active;
    logic [gmsa_pkg::GATES-1:0]  hit;
    logic                        mode_x;
    logic                        mode_y;
    gmsa_pkg::t_row              upd_row;
    logic                        mem_we;
    logic [gmsa_pkg::ADDR_W-1:0] mem_waddr;
    gmsa_pkg::t_row              mem_wdata;
    logic                        mem_re;
    logic [gmsa_pkg::ADDR_W-1:0] mem_raddr;
    logic                        gate_sel;
    logic [gmsa_pkg::DATA_W-1:0] term;
    logic [gmsa_pkg::DATA_W-1:0] n_acc;
    int                          n_active;

    // Window loader: clamp the upper bound, order the pair, clamp again.
    always_comb begin
        hi_c   = (i_gate_high > CH_MAX) ? CH_MAX : i_gate_high;
        new_lo = i_gate_low;
        new_hi = hi_c;
        if (i_gate_low > hi_c) begin
            new_lo = hi_c;
            new_hi = i_gate_low;
        end
        if (new_hi > CH_MAX) begin
            new_hi = CH_MAX;
        end
    end

    // Gates in use and the per-gate window hits for the current update.
    always_comb begin
        n_active = (int'(r_gate_count) > gmsa_pkg::GATES) ? gmsa_pkg::GATES
                                                          : int'(r_gate_count);
        mode_x = (r_slice_mode == gmsa_pkg::MODE_X) || (r_slice_mode == gmsa_pkg::MODE_SUM);
        mode_y = (r_slice_mode == gmsa_pkg::MODE_Y) || (r_slice_mode == gmsa_pkg::MODE_SUM);
        for (int g = 0; g < gmsa_pkg::GATES; g++) begin
            active[g] = (g < n_active);
            if (i_cmd.wr_y) begin
                hit[g] = active[g] && mode_y &&
                         (r_col >= r_win_lo[g]) && (r_col <= r_win_hi[g]);
            end else begin
                hit[g] = active[g] && mode_x &&
                         (r_row >= r_win_lo[g]) && (r_row <= r_win_hi[g]);
            end
            upd_row[g] = r_rd_data[g] + (hit[g] ? r_cnt : '0);
        end
    end

    // Memory port selection.
    always_comb begin
        mem_we    = i_cmd.clr_step ||
                    (i_cmd.wr_x && gmsa_pkg::ch_in_range(r_col)) ||
                    (i_cmd.wr_y && gmsa_pkg::ch_in_range(r_row));
        mem_waddr = i_cmd.clr_step ? r_clr_addr :
                    i_cmd.wr_y     ? r_row[gmsa_pkg::ADDR_W-1:0] :
                                     r_col[gmsa_pkg::ADDR_W-1:0];
        mem_wdata = i_cmd.clr_step ? '0 : upd_row;
        mem_re    = i_cmd.rd_col || i_cmd.rd_row;
        mem_raddr = i_cmd.rd_row ? r_row[gmsa_pkg::ADDR_W-1:0]
                                 : r_col[gmsa_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Readout term for the gate under the counter.
    always_comb begin
        if (r_sum_gates) begin
            gate_sel = (int'(r_gate) < n_active);
        end else begin
            gate_sel = (int'(r_gate) == int'(r_gi));
        end
        term  = (gate_sel && gmsa_pkg::ch_in_range(r_col)) ? r_rd_data[r_gate] : '0;
        n_acc = r_acc + term;
    end

    assign o_status.clr_last = (r_clr_addr == gmsa_pkg::ADDR_W'(gmsa_pkg::CHANNELS - 1));
    assign o_status.sum_last = (r_gate == gmsa_pkg::GATE_W'(gmsa_pkg::GATES - 1));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_mode <= '0;
            r_sum_gates  <= 1'b0;
            r_gate_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gmsa_pkg::CFG_SLICE_MODE: r_slice_mode <= i_cfg_data[1:0];
                gmsa_pkg::CFG_SUM_GATES:  r_sum_gates  <= i_cfg_data[0];
                gmsa_pkg::CFG_GATE_COUNT: r_gate_count <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < gmsa_pkg::GATES; g++) begin
                r_win_lo[g] <= '0;
                r_win_hi[g] <= '0;
            end
        end else if (i_cmd.load_win) begin
            for (int g = 0; g < gmsa_pkg::GATES; g++) begin
                if (int'(i_gate_index) == g) begin
                    r_win_lo[g] <= new_lo;
                    r_win_hi[g] <= new_hi;
                end
            end
        end
    end

    // Request fields are held for the whole request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_gi  <= i_gate_index;
            r_row <= i_row;
            r_col <= i_column;
            r_cnt <= i_count;
        end
    end

    // Sweep counter, gate counter, readout sum and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_gate     <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= o_status.clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.sum_init) begin
                r_gate <= '0;
            end else if (i_cmd.sum_step) begin
                r_gate <= o_status.sum_last ? '0 : r_gate + 1'b1;
            end
            r_valid <= i_cmd.sum_step && o_status.sum_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_acc <= '0;
        end else if (i_cmd.sum_step) begin
            r_acc <= n_acc;
        end
        if (i_cmd.sum_step && o_status.sum_last) begin
            r_out <= n_acc;
        end
    end

    assign o_valid       = r_valid;
    assign o_slice_value = signed'(r_out);

endmodule

// ===== src/gated_matrix_slice_accumulator_top.sv =====
// Gated slice accumulator for a square coincidence matrix. A request is taken when start is
// high and busy is low. Load gate updates its window without raising busy; a matrix element
// makes two read-modify-write passes over one row of the slice store, one at the column and
// one at the row; a read does one memory read, then adds one gate per cycle. The store is a
// single-port-read, single-port-write memory of CHANNELS rows, each row holding the entry of
// every gate. Clear slices, and reset as well, sweep the store one row per cycle while busy
// stays high, and configuration writes are still taken. A read result appears on
// o_slice_value for exactly one cycle with o_valid high; the receiver cannot stall it.
module gated_matrix_slice_accumulator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic [gmsa_pkg::GI_W-1:0]           i_gate_index,
    input  logic [gmsa_pkg::CH_W-1:0]           i_gate_low,
    input  logic [gmsa_pkg::CH_W-1:0]           i_gate_high,
    input  logic [gmsa_pkg::CH_W-1:0]           i_row,
    input  logic [gmsa_pkg::CH_W-1:0]           i_column,
    input  logic signed [gmsa_pkg::DATA_W-1:0]  i_count,
    input  logic                                i_cfg_we,
    input  logic [gmsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gmsa_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic signed [gmsa_pkg::DATA_W-1:0]  o_slice_value
);

    gmsa_pkg::t_cmd    cmd;
    gmsa_pkg::t_status status;

    // Sequencer for the memory passes.
    gmsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Windows, slice store, adders and readout.
    gmsa_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_gate_index  (i_gate_index),
        .i_gate_low    (i_gate_low),
        .i_gate_high   (i_gate_high),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_count       (i_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_slice_value (o_slice_value)
    );

endmodule
